>>> hw/rtl/fss_pkg.sv
// shared constants, threshold table and control types of the similarity score block
package fss_pkg;

	localparam int LANES       = 4;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 2 * ELEM_W;
	localparam int GROUP_W     = PROD_W + $clog2(LANES);
	localparam int ACC_W       = 44;
	localparam int SCORE_W     = 7;
	localparam int SCORE_STEPS = 100;
	localparam int THR_W       = 30;
	localparam int BIT_W       = $clog2(SCORE_W);

	typedef logic signed [ELEM_W-1:0]  elem_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [GROUP_W-1:0] group_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic [SCORE_W-1:0]        score_t;
	typedef logic [THR_W-1:0]          thr_t;
	typedef thr_t                      thr_table_t [SCORE_STEPS+1];
	typedef int unsigned               micro_table_t [SCORE_STEPS+1];

	// thresholds in millionths
	localparam micro_table_t MICRO = '{
		     0,  13366,  16732,  20099,  23465,  26831,  30197,  33563,  36930,  40296,
		 43662,  47028,  50394,  53761,  57127,  60493,  63859,  67225,  70592,  73958,
		 77324,  80690,  84056,  87423,  90789,  94155,  97521, 100887, 104254, 107620,
		110986, 114352, 117718, 121085, 124451, 127817, 131183, 134549, 137915, 141282,
		144648, 148014, 151380, 154746, 158113, 161479, 164845, 168211, 171577, 174944,
		178310, 181676, 185042, 188408, 191775, 195141, 198507, 201873, 205239, 208606,
		211972, 215338, 218704, 222070, 225437, 228803, 232169, 235535, 238901, 242268,
		245634, 249000, 257750, 266500, 275250, 284000, 292750, 301500, 310250, 319000,
		328000, 337000, 346000, 355000, 364000, 373000, 399600, 426200, 452800, 479400,
		506000, 517800, 529600, 541400, 553200, 565000, 600000, 635000, 670000, 705000,
		715000
	};

	function automatic thr_table_t build_thr();
		thr_table_t        t;
		longint unsigned   m;
		for (int k = 0; k <= SCORE_STEPS; k++) begin
			m    = longint'(MICRO[k]);
			t[k] = THR_W'((m * 64'd1073741824 + 64'd500000) / 64'd1000000);
		end
		return t;
	endfunction

	// thresholds in q.30, rounded
	localparam thr_table_t THR = build_thr();

	typedef struct packed {
		logic             take;
		logic             sum;
		logic             acc;
		logic             step;
		logic [BIT_W-1:0] bit_idx;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_ready;
	} status_t;

endpackage

>>> hw/rtl/fss_datapath.sv
// datapath: lane multipliers, group adder, saturating accumulator, threshold search, output register
module fss_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fss_pkg::elem_t        first_lane [fss_pkg::LANES],
	input  fss_pkg::elem_t        second_lane [fss_pkg::LANES],
	input  logic                  last_group,
	input  fss_pkg::cmd_t         cmd,
	output fss_pkg::status_t      status,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fss_pkg::score_t       similarity_score
);

	fss_pkg::prod_t  prod_s1 [fss_pkg::LANES];
	logic            last_q;
	fss_pkg::group_t group_s2;
	fss_pkg::acc_t   acc_q;
	fss_pkg::acc_t   srch_sum_q;
	fss_pkg::score_t srch_score_q;
	fss_pkg::score_t score_q;
	logic            out_valid_q;

	fss_pkg::group_t                group_c;
	logic signed [fss_pkg::ACC_W:0] acc_wide;
	fss_pkg::acc_t                  acc_sat;
	fss_pkg::score_t                cand;
	fss_pkg::thr_t                  thr_sel;
	logic                           meet;

	always_comb begin
		group_c = '0;
		for (int i = 0; i < fss_pkg::LANES; i++) begin
			group_c = group_c + fss_pkg::GROUP_W'(prod_s1[i]);
		end
	end

	always_comb begin
		acc_wide = (fss_pkg::ACC_W+1)'(acc_q) + (fss_pkg::ACC_W+1)'(group_s2);
		if (acc_wide[fss_pkg::ACC_W] != acc_wide[fss_pkg::ACC_W-1]) begin
			acc_sat = acc_wide[fss_pkg::ACC_W] ?
				{1'b1, {(fss_pkg::ACC_W-1){1'b0}}} : {1'b0, {(fss_pkg::ACC_W-1){1'b1}}};
		end else begin
			acc_sat = acc_wide[fss_pkg::ACC_W-1:0];
		end
	end

	// one bit of the score per step, table is increasing
	always_comb begin
		cand    = srch_score_q | (fss_pkg::SCORE_W'(1) << cmd.bit_idx);
		thr_sel = (cand <= fss_pkg::SCORE_W'(fss_pkg::SCORE_STEPS)) ?
			fss_pkg::THR[cand] : '0;
		meet    = (cand <= fss_pkg::SCORE_W'(fss_pkg::SCORE_STEPS)) &&
			!srch_sum_q[fss_pkg::ACC_W-1] &&
			(srch_sum_q[fss_pkg::ACC_W-2:0] >= (fss_pkg::ACC_W-1)'(thr_sel));
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			for (int i = 0; i < fss_pkg::LANES; i++) begin
				prod_s1[i] <= fss_pkg::PROD_W'(first_lane[i]) * fss_pkg::PROD_W'(second_lane[i]);
			end
			last_q <= last_group;
		end
		if (cmd.sum) begin
			group_s2 <= group_c;
		end
		if (cmd.acc && last_q) begin
			srch_sum_q   <= acc_sat;
			srch_score_q <= '0;
		end else if (cmd.step && meet) begin
			srch_score_q <= cand;
		end
		if (cmd.load_out) begin
			score_q <= srch_score_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				acc_q <= last_q ? '0 : acc_sat;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.last      = last_q;
	assign status.out_ready = !out_valid_q || !out_stall;
	assign out_valid        = out_valid_q;
	assign similarity_score = score_q;

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> score_q <= fss_pkg::SCORE_W'(fss_pkg::SCORE_STEPS))
		else $error("score above table range");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc && last_q |=> acc_q == '0)
		else $error("accumulator not cleared after last item");

	a_negative_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && srch_sum_q[fss_pkg::ACC_W-1] |=> score_q == '0)
		else $error("negative sum gave nonzero score");

endmodule

>>> hw/rtl/fss_ctrl.sv
// controller state machine sequencing accumulate, search and output load
module fss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  fss_pkg::status_t status,
	output fss_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_ACC,
		ST_SRCH,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [fss_pkg::BIT_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (status.last) begin
						state_q <= ST_SRCH;
						step_q  <= fss_pkg::BIT_W'(fss_pkg::SCORE_W - 1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SRCH: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (status.out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		cmd.take     = (state_q == ST_IDLE) && in_valid;
		cmd.sum      = (state_q == ST_SUM);
		cmd.acc      = (state_q == ST_ACC);
		cmd.step     = (state_q == ST_SRCH);
		cmd.bit_idx  = step_q;
		cmd.load_out = (state_q == ST_DONE) && status.out_ready;
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_ready)
		else $error("output loaded while occupied");

	a_search_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH && step_q == '0 |=> state_q == ST_DONE)
		else $error("search did not finish after last bit");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !status.out_ready |=> state_q == ST_DONE)
		else $error("score left the controller while output occupied");

endmodule

>>> hw/rtl/feature_similarity_score.sv
// top level of the dot-product similarity score block
//
// input channel: in_valid/in_stall carry one item of four signed q1.15 element
// pairs plus last_group. products of the pairs are summed into a 44-bit
// saturating q.30 accumulator.
// output channel: out_valid/out_stall carry one similarity_score (0..100) per
// item marked last_group: the highest table index whose threshold the sum
// meets, 0 when none is met. the accumulator is cleared after that item.
// an item without last_group is multiplied on accept, its group is added,
// then accumulated; in_stall is high while the add and accumulate states
// run. an item with last_group goes through the same steps plus a 7-step
// binary search of the threshold table, one compare per cycle, plus the
// output load; out_valid is registered from that load.
// the output register frees the input side: a new item is taken while a
// score waits. a stalled score holds; a second score waits in the controller
// until the output register is taken.
// reset clears the accumulator, the controller and out_valid.
module feature_similarity_score (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  fss_pkg::elem_t         first_lane0,
	input  fss_pkg::elem_t         first_lane1,
	input  fss_pkg::elem_t         first_lane2,
	input  fss_pkg::elem_t         first_lane3,
	input  fss_pkg::elem_t         second_lane0,
	input  fss_pkg::elem_t         second_lane1,
	input  fss_pkg::elem_t         second_lane2,
	input  fss_pkg::elem_t         second_lane3,
	input  logic                   last_group,
	output logic                   out_valid,
	input  logic                   out_stall,
	output fss_pkg::score_t        similarity_score
);

	fss_pkg::elem_t   first_lane [fss_pkg::LANES];
	fss_pkg::elem_t   second_lane [fss_pkg::LANES];
	fss_pkg::cmd_t    cmd;
	fss_pkg::status_t status;

	assign first_lane[0]  = first_lane0;
	assign first_lane[1]  = first_lane1;
	assign first_lane[2]  = first_lane2;
	assign first_lane[3]  = first_lane3;
	assign second_lane[0] = second_lane0;
	assign second_lane[1] = second_lane1;
	assign second_lane[2] = second_lane2;
	assign second_lane[3] = second_lane3;

	fss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	fss_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.first_lane       (first_lane),
		.second_lane      (second_lane),
		.last_group       (last_group),
		.cmd              (cmd),
		.status           (status),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.similarity_score (similarity_score)
	);

endmodule
